/* hw/rtl/cbor_stream_tokenizer_macros.svh */
// Assertion macros for the CBOR stream tokenizer.
// Used by the top level; the clock and reset names of that module are assumed.
`ifndef CBOR_STREAM_TOKENIZER_MACROS_SVH
`define CBOR_STREAM_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbst check failed");

// Next-cycle implication, disabled during reset.
`define CBST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbst check failed");

`endif

/* hw/rtl/cbst_pkg.sv */
// Shared types and constants for the CBOR stream tokenizer.
// No dependencies; imported by the head decoder and the top level.
package cbst_pkg;

   // Item types reported in a token.
   localparam logic [2:0] TYPE_NUMBER = 3'd0;
   localparam logic [2:0] TYPE_BYTES  = 3'd1;
   localparam logic [2:0] TYPE_TEXT   = 3'd2;
   localparam logic [2:0] TYPE_ARRAY  = 3'd3;
   localparam logic [2:0] TYPE_MAP    = 3'd4;
   localparam logic [2:0] TYPE_BOOL   = 3'd5;
   localparam logic [2:0] TYPE_NULL   = 3'd6;

   // Status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ST_OVERRUN     = 2'd2;
   localparam logic [1:0] ST_OVERFLOW    = 2'd3;

   // Result kinds.
   localparam logic KIND_ITEM    = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // CBOR major types.
   localparam logic [2:0] MAJ_UINT   = 3'd0;
   localparam logic [2:0] MAJ_BYTES  = 3'd2;
   localparam logic [2:0] MAJ_TEXT   = 3'd3;
   localparam logic [2:0] MAJ_ARRAY  = 3'd4;
   localparam logic [2:0] MAJ_MAP    = 3'd5;
   localparam logic [2:0] MAJ_SIMPLE = 3'd7;

   // Additional-info codes.
   localparam logic [4:0] MINOR_FALSE     = 5'd20;
   localparam logic [4:0] MINOR_TRUE      = 5'd21;
   localparam logic [4:0] MINOR_NULL      = 5'd22;
   localparam logic [4:0] MINOR_SHORT_MAX = 5'd23;
   localparam logic [4:0] MINOR_ARG_MAX   = 5'd27;

   // Register map.
   localparam int unsigned CsrAddrWidth = 3;
   localparam logic        CSR_IDX_DOC_LENGTH = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       doc_start;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  item_type;
      logic [63:0] arg_value;
      logic [3:0]  head_length;
      logic [15:0] item_offset;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic [1:0]  status;
      logic        doc_done;
   } rsp_item_type;

   // Decoded view of one byte taken as an initial byte, plus position checks.
   typedef struct packed {
      logic        past_end;     // offset at or beyond the document length
      logic        done;         // byte is the last one of the document
      logic [15:0] remaining;    // bytes left after this one
      logic        unsupported;  // major type or simple value not handled
      logic        simple;       // boolean or null
      logic [2:0]  item_type;
      logic        simple_arg;   // 1 for true
      logic        short_arg;    // argument held in the initial byte
      logic        bad_minor;    // additional info 28 to 31
      logic [3:0]  arg_bytes;    // 1, 2, 4 or 8
      logic        arg_overrun;  // argument bytes run past the end
   } head_info_type;

endpackage

/* hw/rtl/cbst_head_dec.sv */
// Initial-byte decoder and position checks for the CBOR stream tokenizer.
// Depends on cbst_pkg.
module cbst_head_dec
   import cbst_pkg::*;
(
   input  logic [7:0]    data_byte,
   input  logic [15:0]   offset,
   input  logic [15:0]   doc_length,
   output head_info_type info
);

   logic [2:0]  major;
   logic [4:0]  minor;
   logic [16:0] next_pos;

   assign major    = data_byte[7:5];
   assign minor    = data_byte[4:0];
   assign next_pos = {1'b0, offset} + 17'd1;

   always_comb begin
      // Position of this byte against the configured length.
      info.past_end = (offset >= doc_length);
      info.done     = (next_pos == {1'b0, doc_length});
      if ({1'b0, doc_length} > next_pos) begin
         info.remaining = doc_length - next_pos[15:0];
      end else begin
         info.remaining = '0;
      end

      // Major type and additional info.
      info.unsupported = 1'b0;
      info.simple      = 1'b0;
      info.simple_arg  = (minor == MINOR_TRUE);
      info.item_type   = TYPE_NUMBER;
      case (major)
         MAJ_UINT:  info.item_type = TYPE_NUMBER;
         MAJ_BYTES: info.item_type = TYPE_BYTES;
         MAJ_TEXT:  info.item_type = TYPE_TEXT;
         MAJ_ARRAY: info.item_type = TYPE_ARRAY;
         MAJ_MAP:   info.item_type = TYPE_MAP;
         MAJ_SIMPLE: begin
            if (minor inside {MINOR_FALSE, MINOR_TRUE}) begin
               info.simple    = 1'b1;
               info.item_type = TYPE_BOOL;
            end else if (minor == MINOR_NULL) begin
               info.simple    = 1'b1;
               info.item_type = TYPE_NULL;
            end else begin
               info.unsupported = 1'b1;
            end
         end
         default: info.unsupported = 1'b1;
      endcase
      info.short_arg   = (minor <= MINOR_SHORT_MAX);
      info.bad_minor   = (minor > MINOR_ARG_MAX);
      info.arg_bytes   = 4'b0001 << minor[1:0];
      info.arg_overrun = ({12'd0, info.arg_bytes} > info.remaining);
   end

endmodule

/* hw/rtl/cbor_stream_tokenizer.sv */
// Top level of the CBOR stream tokenizer: handshakes, walk state and result register.
// Depends on cbst_pkg, cbst_head_dec and cbor_stream_tokenizer_macros.svh.
//
//   Channel  Direction  Handshake                 Carries
//   req      in         req_valid / req_stall     req_item_type (one document byte)
//   rsp      out        rsp_valid / rsp_stall     rsp_item_type (token or payload byte)
//   csr      in         APB psel/penable/pwrite   doc_length at byte addresses 0 to 3
//
// One byte is taken per cycle unless the input stalls; its result, if any, is in the output register in the next cycle.
// The whole step for a byte is one pass of logic between the byte and the result register.
// Reset is synchronous and clears the walk state, the output valid and doc_length.
// The input stalls only while a result sits in the output register and rsp_stall is high.
`include "cbor_stream_tokenizer_macros.svh"

module cbor_stream_tokenizer
   import cbst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_item,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   typedef enum logic [3:0] {
      PH_HEAD    = 4'b0001,
      PH_ARG     = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_ERROR   = 4'b1000
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [3:0]   arg_left_ff, arg_left_in;
   logic [63:0]  acc_ff, acc_in;
   logic [2:0]   cur_type_ff, cur_type_in;
   logic [3:0]   cur_hl_ff, cur_hl_in;
   logic [15:0]  cur_off_ff, cur_off_in;
   logic [15:0]  offset_ff, offset_in;
   logic [15:0]  payload_left_ff, payload_left_in;
   logic [15:0]  doc_length_ff, doc_length_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic          in_acc;
   logic          res_valid;
   rsp_item_type  res;
   phase_type     eff_phase;
   logic [15:0]   eff_offset;
   logic [15:0]   eff_payload_left;
   logic [3:0]    eff_arg_left;
   logic [63:0]   eff_acc;
   head_info_type info;

   logic [63:0]   fin_value;
   logic [2:0]    fin_type;
   logic [1:0]    fin_status;
   logic          fin_payload;
   logic [63:0]   acc_shift;
   logic [3:0]    arg_left_dec;
   logic [15:0]   payload_left_dec;

   // Handshakes: the input moves unless a held result is stalled.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign in_acc    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Register port: writes complete on the access cycle.
   assign pready = 1'b1;
   always_comb begin
      doc_length_in = doc_length_ff;
      if (psel && penable && pwrite && (paddr[CsrAddrWidth-1] == CSR_IDX_DOC_LENGTH)) begin
         doc_length_in = pwdata[15:0];
      end
      if (paddr[CsrAddrWidth-1] == CSR_IDX_DOC_LENGTH) begin
         prdata = {16'd0, doc_length_ff};
      end else begin
         prdata = '0;
      end
   end

   // A document start drops any pending head, payload or error.
   always_comb begin
      if (req_item.doc_start) begin
         eff_phase        = PH_HEAD;
         eff_offset       = '0;
         eff_payload_left = '0;
         eff_arg_left     = '0;
         eff_acc          = '0;
      end else begin
         eff_phase        = phase_ff;
         eff_offset       = offset_ff;
         eff_payload_left = payload_left_ff;
         eff_arg_left     = arg_left_ff;
         eff_acc          = acc_ff;
      end
   end

   cbst_head_dec u_head_dec (
      .data_byte  (req_item.data_byte),
      .offset     (eff_offset),
      .doc_length (doc_length_ff),
      .info       (info)
   );

   // Head completion checks, shared by short heads and the last argument byte.
   assign acc_shift        = {eff_acc[55:0], req_item.data_byte};
   assign arg_left_dec     = (eff_arg_left != 4'd0) ? eff_arg_left - 4'd1 : eff_arg_left;
   assign payload_left_dec = (eff_payload_left != 16'd0) ? eff_payload_left - 16'd1
                                                          : eff_payload_left;
   always_comb begin
      if (eff_phase == PH_ARG) begin
         fin_value = acc_shift;
         fin_type  = cur_type_ff;
      end else begin
         fin_value = {59'd0, req_item.data_byte[4:0]};
         fin_type  = info.item_type;
      end
      fin_status  = ST_OK;
      fin_payload = 1'b0;
      if (fin_type == TYPE_BYTES || fin_type == TYPE_TEXT) begin
         if (fin_value > {48'd0, info.remaining}) begin
            fin_status = ST_OVERRUN;
         end else if (fin_value[63:32] != 32'd0) begin
            fin_status = ST_OVERFLOW;
         end else if (fin_value != 64'd0) begin
            fin_payload = 1'b1;
         end
      end else if (fin_type == TYPE_ARRAY || fin_type == TYPE_MAP) begin
         if (fin_value[63:32] != 32'd0) begin
            fin_status = ST_OVERFLOW;
         end
      end
   end

   // One step of the walk for the accepted byte.
   always_comb begin
      phase_in        = phase_ff;
      arg_left_in     = arg_left_ff;
      acc_in          = acc_ff;
      cur_type_in     = cur_type_ff;
      cur_hl_in       = cur_hl_ff;
      cur_off_in      = cur_off_ff;
      offset_in       = offset_ff;
      payload_left_in = payload_left_ff;
      res_valid       = 1'b0;
      res             = '0;
      res.doc_done    = info.done;

      if (in_acc) begin
         phase_in        = eff_phase;
         offset_in       = eff_offset;
         payload_left_in = eff_payload_left;
         arg_left_in     = eff_arg_left;
         acc_in          = eff_acc;
         if (eff_phase != PH_ERROR) begin
            if (eff_offset != 16'hffff) begin
               offset_in = eff_offset + 16'd1;
            end
            case (eff_phase)
               PH_PAYLOAD: begin
                  payload_left_in  = payload_left_dec;
                  res_valid        = 1'b1;
                  res.result_kind  = KIND_PAYLOAD;
                  res.item_type    = cur_type_ff;
                  res.head_length  = cur_hl_ff;
                  res.item_offset  = cur_off_ff;
                  res.payload_byte = req_item.data_byte;
                  res.payload_last = (payload_left_dec == 16'd0);
                  if (payload_left_dec == 16'd0) begin
                     phase_in = PH_HEAD;
                  end
               end
               PH_ARG: begin
                  acc_in      = acc_shift;
                  arg_left_in = arg_left_dec;
                  if (arg_left_dec == 4'd0) begin
                     res_valid       = 1'b1;
                     res.item_type   = fin_type;
                     res.arg_value   = fin_value;
                     res.head_length = cur_hl_ff;
                     res.item_offset = cur_off_ff;
                     res.status      = fin_status;
                     if (fin_status != ST_OK) begin
                        phase_in = PH_ERROR;
                     end else if (fin_payload) begin
                        phase_in        = PH_PAYLOAD;
                        payload_left_in = fin_value[15:0];
                     end else begin
                        phase_in = PH_HEAD;
                     end
                  end
               end
               PH_HEAD: begin
                  cur_off_in      = eff_offset;
                  cur_hl_in       = 4'd1;
                  res.item_offset = eff_offset;
                  res.head_length = 4'd1;
                  if (info.past_end || info.unsupported) begin
                     res_valid     = 1'b1;
                     res.item_type = TYPE_NUMBER;
                     res.status    = info.past_end ? ST_OVERRUN : ST_UNSUPPORTED;
                     phase_in      = PH_ERROR;
                  end else if (info.simple) begin
                     res_valid     = 1'b1;
                     res.item_type = info.item_type;
                     res.arg_value = {63'd0, info.simple_arg};
                  end else begin
                     cur_type_in = info.item_type;
                     if (info.short_arg) begin
                        res_valid     = 1'b1;
                        res.item_type = fin_type;
                        res.arg_value = fin_value;
                        res.status    = fin_status;
                        if (fin_status != ST_OK) begin
                           phase_in = PH_ERROR;
                        end else if (fin_payload) begin
                           phase_in        = PH_PAYLOAD;
                           payload_left_in = fin_value[15:0];
                        end
                     end else if (info.bad_minor || info.arg_overrun) begin
                        res_valid     = 1'b1;
                        res.item_type = info.item_type;
                        res.status    = info.bad_minor ? ST_UNSUPPORTED : ST_OVERRUN;
                        phase_in      = PH_ERROR;
                     end else begin
                        arg_left_in = info.arg_bytes;
                        acc_in      = '0;
                        cur_hl_in   = 4'd1 + info.arg_bytes;
                        phase_in    = PH_ARG;
                     end
                  end
               end
               default: phase_in = PH_ERROR;
            endcase
         end
      end
   end

   // Output register: loads a new result, holds one that is stalled.
   always_comb begin
      rsp_valid_in = res_valid | (rsp_valid_ff & rsp_stall);
      rsp_item_in  = res_valid ? res : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEAD;
         arg_left_ff     <= '0;
         acc_ff          <= '0;
         cur_type_ff     <= '0;
         cur_hl_ff       <= '0;
         cur_off_ff      <= '0;
         offset_ff       <= '0;
         payload_left_ff <= '0;
         doc_length_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         arg_left_ff     <= arg_left_in;
         acc_ff          <= acc_in;
         cur_type_ff     <= cur_type_in;
         cur_hl_ff       <= cur_hl_in;
         cur_off_ff      <= cur_off_in;
         offset_ff       <= offset_in;
         payload_left_ff <= payload_left_in;
         doc_length_ff   <= doc_length_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // A walk stopped by an error stays silent until the next document start.
   `CBST_ASSERT_NOW(a_error_silent,
      in_acc && !req_item.doc_start && (phase_ff == PH_ERROR), !res_valid)
   // Any error status sends the walk to the error phase.
   `CBST_ASSERT_NEXT(a_error_stops, res_valid && (res.status != ST_OK),
      phase_ff == PH_ERROR)
   // Payload phase always has bytes pending.
   `CBST_ASSERT_NOW(a_payload_count, phase_ff == PH_PAYLOAD, payload_left_ff != 16'd0)
   // Argument phase always has argument bytes pending.
   `CBST_ASSERT_NOW(a_arg_count, phase_ff == PH_ARG, arg_left_ff != 4'd0)
   // Only payload results carry the last-byte mark.
   `CBST_ASSERT_NOW(a_last_on_payload,
      rsp_valid_ff && (rsp_item_ff.result_kind == KIND_ITEM), !rsp_item_ff.payload_last)

endmodule
